### rtl/fmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmq_pkg
// shared types and constants for the minifloat quantizer pipeline
// ----------------------------------------------------------------------------
package fmq_pkg;

    // configuration register indexes
    localparam logic [5:0] REG_REF_EXP   = 6'd0;
    localparam logic [5:0] REG_EXP_BITS  = 6'd1;
    localparam logic [5:0] REG_TOT_BITS  = 6'd2;
    localparam logic [5:0] REG_SIGN      = 6'd3;

    localparam logic [31:0] POS_INF      = 32'h7F80_0000;
    localparam logic [30:0] MAG_MASK     = 31'h7FFF_FFFF;

    // settings decoded once from the registers
    typedef struct packed {
        logic        cfg_err;
        logic [8:0]  e0;        // signed reference exponent
        logic [8:0]  emax;      // 2^exp_bits - 1
        logic [4:0]  nm;        // mantissa bits 1..23
        logic [5:0]  nb;        // magnitude bits
        logic        sign_en;
    } cfg_t;

    // stage 1 -> stage 2
    typedef struct packed {
        logic        last;
        logic        cfg_err;
        logic        neg;
        logic        zero;      // rebased exponent below one
        logic        inf;       // product is infinity
        logic        sub;       // product denormal
        logic [9:0]  p;         // product exponent (or shift amount when sub)
        logic [22:0] man;
    } s1_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic        last;
        logic        cfg_err;
        logic        neg;
        logic [31:0] y;         // product bit pattern
    } s2_t;

    function automatic logic [8:0] emax_of(input logic [3:0] n);
        logic [8:0] r;
        begin
            case (n)
                4'd0: r = 9'd0;
                4'd1: r = 9'd1;
                4'd2: r = 9'd3;
                4'd3: r = 9'd7;
                4'd4: r = 9'd15;
                4'd5: r = 9'd31;
                4'd6: r = 9'd63;
                4'd7: r = 9'd127;
                default: r = 9'd255;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/fmq_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmq_cfg
// configuration registers and decode of the derived sizes
// ----------------------------------------------------------------------------
module fmq_cfg
    import fmq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    logic [8:0] ref_reg;
    logic [3:0] eb_reg;
    logic [5:0] tb_reg;
    logic       sgn_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= 9'd0;
            eb_reg  <= 4'd4;
            tb_reg  <= 6'd16;
            sgn_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REF_EXP:  ref_reg <= cfg_data[8:0];
                REG_EXP_BITS: eb_reg  <= cfg_data[3:0];
                REG_TOT_BITS: tb_reg  <= cfg_data[5:0];
                REG_SIGN:     sgn_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [7:0] nb_s;
    logic signed [7:0] nm_s;

    // derived sizes
    always_comb
    begin
        nb_s = $signed({2'b00, tb_reg}) - $signed({7'd0, sgn_reg});
        nm_s = nb_s - $signed({4'd0, eb_reg});
        cfg.cfg_err = (eb_reg < 4'd1) || (eb_reg > 4'd8) || (nm_s < 8'sd1) || (nm_s > 8'sd23);
        cfg.e0      = ref_reg;
        cfg.emax    = emax_of(eb_reg);
        cfg.nm      = nm_s[4:0];
        cfg.nb      = nb_s[5:0];
        cfg.sign_en = sgn_reg;
    end

endmodule
`default_nettype wire

### rtl/fmq_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmq_pipe
// three-stage datapath: round and rebase, scale, truncate and clamp
// ----------------------------------------------------------------------------
module fmq_pipe
    import fmq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] value_bits,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      quantized,
    output logic             config_error,
    output logic             last_out
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic [31:0] q_reg, q_next;
    logic        err_reg, last_reg;

    // stall chain: a stage moves when the one after it is free
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    logic [30:0] rnd;
    logic [31:0] z;
    logic signed [10:0] eb;
    logic signed [10:0] pp;

    // stage 1: rounding add, rebase, product exponent
    always_comb
    begin
        rnd = (cfg.nm < 5'd23) ? (31'd1 << (5'd22 - cfg.nm)) : 31'd0;
        z   = {1'b0, value_bits[30:0] & MAG_MASK} + {1'b0, rnd};
        eb  = $signed({2'b00, z[31:23]}) - $signed({{2{cfg.e0[8]}}, cfg.e0});
        pp  = eb + $signed({2'b00, cfg.emax}) - 11'sd127;
        s1_next.last    = last_in;
        s1_next.cfg_err = cfg.cfg_err;
        s1_next.neg     = value_bits[31] & cfg.sign_en;
        s1_next.zero    = (eb < 11'sd1);
        s1_next.inf     = (cfg.emax >= 9'd255) || (eb >= 11'sd255) || (pp >= 11'sd255);
        s1_next.sub     = (pp < 11'sd1);
        s1_next.p       = (pp < 11'sd1) ? (10'd1 - pp[9:0]) : pp[9:0];
        s1_next.man     = z[22:0];
    end

    logic [23:0] sig, kept, rem, half;
    logic [4:0]  sh;

    // stage 2: scaling multiply by a power of two, nearest-even when denormal
    always_comb
    begin
        sig  = {1'b1, s1_reg.man};
        sh   = s1_reg.p[4:0];
        kept = sig >> sh;
        rem  = sig & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);
        s2_next.last    = s1_reg.last;
        s2_next.cfg_err = s1_reg.cfg_err;
        s2_next.neg     = s1_reg.neg;
        if (s1_reg.zero)
            s2_next.y = 32'd0;
        else if (s1_reg.inf)
            s2_next.y = POS_INF;
        else if (!s1_reg.sub)
            s2_next.y = {1'b0, s1_reg.p[7:0], s1_reg.man};
        // a shift of 25 or more leaves less than half of the smallest denormal
        else if (s1_reg.p > 10'd24)
            s2_next.y = 32'd0;
        else if (rem > half || (rem == half && kept[0]))
            s2_next.y = {8'd0, kept + 24'd1};
        else
            s2_next.y = {8'd0, kept};
    end

    logic [31:0] qs, lim;

    // stage 3: drop low bits, clamp, sign, zero on a configuration error
    always_comb
    begin
        qs  = s2_reg.y >> (5'd23 - cfg.nm);
        lim = 32'(({1'b0, 32'd1} << cfg.nb) - 33'd1);
        if (qs > lim)
            qs = lim;
        if (s2_reg.cfg_err)
            q_next = 32'd0;
        else if (s2_reg.neg)
            q_next = 32'd0 - qs;
        else
            q_next = qs;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3)
        begin
            q_reg    <= q_next;
            err_reg  <= s2_reg.cfg_err;
            last_reg <= s2_reg.last;
        end
    end

    assign out_valid    = v3_reg;
    assign quantized    = q_reg;
    assign config_error = err_reg;
    assign last_out     = last_reg;

endmodule
`default_nettype wire

### rtl/float_to_minifloat_quantizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_to_minifloat_quantizer_top
// converts single-precision patterns into reduced-float integer tokens
// ----------------------------------------------------------------------------
// One item is accepted per cycle unless a stall holds the input side. The
// accepting edge loads the first of three register stages (round and rebase,
// scale, truncate and clamp), and the result is on the outputs from the third.
// A stalled output holds only the stages that are full; empty stages keep
// filling. Write configuration only while no item is in flight.
module float_to_minifloat_quantizer_top
    import fmq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] value_bits,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      quantized,
    output logic             config_error,
    output logic             last_out
);

    cfg_t cfg;

    // configuration
    fmq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // datapath
    fmq_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value_bits   (value_bits),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quantized    (quantized),
        .config_error (config_error),
        .last_out     (last_out)
    );

`ifndef SYNTHESIS
    // an error result always carries a zero token
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && config_error |-> quantized == 32'd0)
        else $error("error item with nonzero token");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quantized))
        else $error("stalled result changed");

    // output side free means input side ready
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("ready lost while output drains");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the minifloat quantizer against a bit-exact predictor of the token,
// over directed corner patterns and random patterns under several settings,
// with random gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module testbench
    import fmq_pkg::*;
();

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] bits;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [31:0] token;
        logic        err;
        logic        last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value_bits;
    logic        last_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] quantized;
    logic        config_error;
    logic        last_out;
    logic        in_ready_seen;

    // predictor copy of the registers
    logic [8:0] ref_exp_q;
    logic [3:0] exp_bits_q;
    logic [5:0] tot_bits_q;
    logic       sign_q;

    sample_t pending_samples[$];
    token_t  expected_tokens[$];
    int      fail_count;
    int      idle_cycles;
    int      gap_left;
    int      stall_left;

    float_to_minifloat_quantizer_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .value_bits(value_bits), .last_in(last_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .quantized(quantized), .config_error(config_error), .last_out(last_out)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // scaled product pattern of a positive normal magnitude
    function automatic logic [31:0] scale_product(input int eb, input logic [22:0] man,
                                                  input int emax);
        int          p;
        int          s;
        logic [31:0] sig;
        logic [31:0] kept;
        logic [31:0] rem;
        logic [31:0] half;
        if (emax >= 255 || eb >= 255)
            return POS_INF;
        p = eb + emax - 127;
        if (p >= 255)
            return POS_INF;
        if (p >= 1)
            return {1'b0, p[7:0], man};
        s = 1 - p;
        if (s > 25)
            return 32'd0;
        sig  = {9'd0, man} | 32'h0080_0000;
        kept = sig >> s;
        rem  = sig & ((32'd1 << s) - 32'd1);
        half = 32'd1 << (s - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 32'd1;
        return kept;
    endfunction

    // expected token for one sample under the current settings
    function automatic token_t quantize(input sample_t smp);
        token_t      r;
        int          nexp;
        int          nb;
        int          nm;
        int          e0;
        int          eb;
        int          emax;
        logic [31:0] rnd;
        logic [31:0] z;
        logic [31:0] lim;
        logic [31:0] y;
        logic [31:0] q;
        r.last = smp.last;
        nexp = exp_bits_q;
        nb   = int'(tot_bits_q) - int'(sign_q);
        nm   = nb - nexp;
        if (nexp < 1 || nexp > 8 || nm < 1 || nm > 23)
        begin
            r.token = 32'd0;
            r.err   = 1'b1;
            return r;
        end
        r.err = 1'b0;
        e0   = $signed(ref_exp_q);
        emax = (1 << nexp) - 1;
        lim  = (32'd1 << nb) - 32'd1;
        rnd  = (nm < 23) ? (32'd1 << (22 - nm)) : 32'd0;
        z    = {1'b0, smp.bits[30:0]} + rnd;
        eb   = int'(z[31:23]) - e0;
        if (eb < 1)
            q = 32'd0;
        else
        begin
            y = scale_product(eb, z[22:0], emax);
            q = y >> (23 - nm);
            if (q > lim)
                q = lim;
        end
        if (smp.bits[31] && sign_q)
            q = 32'd0 - q;
        r.token = q;
        return r;
    endfunction

    // driver: next item from the queue after a random gap
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            value_bits <= 32'd0;
            last_in    <= 1'b0;
            gap_left   = $urandom_range(16, 0);
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (gap_left > 0 || pending_samples.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                sample_t smp;
                smp = pending_samples.pop_front();
                expected_tokens.push_back(quantize(smp));
                in_valid   <= 1'b1;
                value_bits <= smp.bits;
                last_in    <= smp.last;
                gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(16, 0);
                if ($urandom_range(2, 0) == 0)
                    gap_left = 0;
            end
        end
    end

    // acceptance flags sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
            in_ready_seen <= in_valid && in_ready;
    end

    // monitor: compare each accepted token with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t unexpected token: expected none, actual %h err %b last %b",
                         $time, quantized, config_error, last_out);
                fail_count = fail_count + 1;
            end
            else
            begin
                token_t exp_tok;
                exp_tok = expected_tokens.pop_front();
                if (quantized !== exp_tok.token)
                begin
                    $display("%0t quantized: expected %h, actual %h",
                             $time, exp_tok.token, quantized);
                    fail_count = fail_count + 1;
                end
                if (config_error !== exp_tok.err)
                begin
                    $display("%0t config_error: expected %b, actual %b",
                             $time, exp_tok.err, config_error);
                    fail_count = fail_count + 1;
                end
                if (last_out !== exp_tok.last)
                begin
                    $display("%0t last_out: expected %b, actual %b",
                             $time, exp_tok.last, last_out);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(5, 0) == 0)
                stall_left = $urandom_range(16, 0);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (pending_samples.size() == 0 && expected_tokens.size() == 0))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // write one register while the pipe is empty
    task automatic write_reg(input logic [5:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            REG_REF_EXP:  ref_exp_q  = data[8:0];
            REG_EXP_BITS: exp_bits_q = data[3:0];
            REG_TOT_BITS: tot_bits_q = data[5:0];
            REG_SIGN:     sign_q     = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_setting(input int ref_exp, input int ebits, input int tbits,
                                 input logic sgn);
        write_reg(REG_REF_EXP, 32'(ref_exp));
        write_reg(REG_EXP_BITS, 32'(ebits));
        write_reg(REG_TOT_BITS, 32'(tbits));
        write_reg(REG_SIGN, {31'd0, sgn});
    endtask

    // wait until all tokens of the current phase are back
    task automatic drain;
        while (pending_samples.size() != 0 || expected_tokens.size() != 0 || in_valid)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [31:0] random_pattern();
        logic [31:0] v;
        v = $urandom();
        // mostly exponents near the reference so the token is not saturated
        if ($urandom_range(3, 0) != 0)
            v[30:23] = 8'($signed(ref_exp_q) + 127 - int'($urandom_range(20, 0)) + 4);
        return v;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            pending_samples.push_back('{bits: random_pattern(),
                                        last: 1'($urandom_range(1, 0))});
        drain();
    endtask

    task automatic directed_phase;
        logic [31:0] pats[$];
        pats = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
                 32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3FFF_FFFF,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h3F7F_FFFF,
                 32'h3E80_0000, 32'hC2F6_E979, 32'h0040_0000, 32'h7FFF_FFFF};
        foreach (pats[i])
            pending_samples.push_back('{bits: pats[i], last: 1'(i % 2)});
        drain();
    endtask

    initial
    begin
        fail_count = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = 6'd0;
        cfg_data   = 32'd0;
        ref_exp_q  = 9'd0;
        exp_bits_q = 4'd4;
        tot_bits_q = 6'd16;
        sign_q     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings
        directed_phase();
        random_phase(100);

        // signed, wide mantissa, no rounding room
        apply_setting(0, 8, 32, 1'b1);
        directed_phase();
        random_phase(100);
        apply_setting(-127, 1, 3, 1'b1);
        directed_phase();
        random_phase(100);
        apply_setting(128, 8, 9, 1'b0);
        directed_phase();
        random_phase(100);
        apply_setting(-1, 5, 20, 1'b1);
        random_phase(150);
        apply_setting(3, 2, 25, 1'b0);
        random_phase(100);
        // invalid sizes, then a legal setting with 23 mantissa bits
        apply_setting(255, 0, 16, 1'b0);
        directed_phase();
        apply_setting(0, 15, 63, 1'b1);
        random_phase(20);
        apply_setting(0, 8, 33, 1'b1);
        random_phase(20);
        apply_setting(0, 4, 5, 1'b1);
        random_phase(20);
        apply_setting(0, 3, 26, 1'b0);
        random_phase(20);
        // a spread of random settings, legal unless the sign bit is off with 23 mantissa bits
        for (int k = 0; k < 5; k++)
        begin
            int eb;
            int nm;
            eb = $urandom_range(8, 1);
            nm = $urandom_range(23, 1);
            apply_setting(int'($urandom_range(255, 0)) - 127, eb, eb + nm + 1,
                          1'($urandom));
            random_phase(60);
        end

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
